/* rtl/core/bvcp_pkg.sv */
// ----------------------------------------------------------------------------
// bvcp_pkg: shared definitions for the battery charge estimator
// Field widths, register reset value, discharge curve points and the status
// type that the serial arithmetic units report through.
// ----------------------------------------------------------------------------
package bvcp_pkg;

	localparam int SAMPLES_DEF = 8;
	localparam int SAMPLES_MAX = 32;

	localparam int SAMPLE_W = 12;
	localparam int RATIO_W  = 12;
	localparam int MV_W     = 16;
	localparam int PCT_W    = 7;
	localparam int SUM_W    = 18;
	localparam int CNT_W    = 6;

	// Divider operand widths: the sum is the widest dividend, and the
	// largest divisor is the 200 mV span of the lowest curve segment.
	localparam int DIV_DW = SUM_W;
	localparam int DIV_VW = 8;

	// Q4.8 ratio: the product is shifted right by this many bits.
	localparam int FRAC_W = 8;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 12'd512;

	localparam int CURVE_PTS = 9;
	localparam int SPAN_PCT_W = 4;
	localparam int DIFF_W = 8;
	localparam int NUM_W = DIFF_W + SPAN_PCT_W;

	localparam logic [MV_W-1:0] CURVE_MV [CURVE_PTS] = '{
		16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800,
		16'd3700, 16'd3600, 16'd3500, 16'd3300
	};
	localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_PTS] = '{
		7'd100, 7'd90, 7'd80, 7'd65, 7'd50, 7'd35, 7'd20, 7'd10, 7'd0
	};

	typedef struct packed {
		logic busy;
		logic done;
	} ser_sts_t;

endpackage

/* rtl/core/bvcp_serdiv.sv */
// ----------------------------------------------------------------------------
// bvcp_serdiv: bit-serial restoring divider
// Produces one quotient bit per cycle, most significant first; a request
// ends with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module bvcp_serdiv #(
	parameter int DW = bvcp_pkg::DIV_DW,
	parameter int VW = bvcp_pkg::DIV_VW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DW-1:0]      dividend,
	input  logic [VW-1:0]      divisor,
	output logic [DW-1:0]      quotient,
	output bvcp_pkg::ser_sts_t sts
);
	import bvcp_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [VW:0]   trial;
	logic          fits;

	// The remainder stays below the divisor, so the trial value needs
	// only one extra bit.
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
		end
	end

	assign quotient = quo_q;
	assign sts      = '{busy: busy_q, done: done_q};

endmodule

/* rtl/core/bvcp_sermul.sv */
// ----------------------------------------------------------------------------
// bvcp_sermul: shift-and-add multiplier
// Consumes one multiplier bit per cycle, least significant first; a request
// ends with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module bvcp_sermul #(
	parameter int W = bvcp_pkg::RATIO_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [W-1:0]       mcand,
	input  logic [W-1:0]       mplier,
	output logic [2*W-1:0]     product,
	output bvcp_pkg::ser_sts_t sts
);
	import bvcp_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [2*W-1:0] acc_q;
	logic [W-1:0]   mcand_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [W:0]     psum;

	// The low half of the accumulator starts out holding the multiplier and
	// is shifted out as the product bits shift in from the top.
	assign psum = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= {{W{1'b0}}, mplier};
			mcand_q <= mcand;
		end else if (busy_q) begin
			acc_q <= {psum, acc_q[W-1:1]};
		end
	end

	assign product = acc_q;
	assign sts     = '{busy: busy_q, done: done_q};

endmodule

/* rtl/core/battery_voltage_to_charge_percent.sv */
// ----------------------------------------------------------------------------
// battery_voltage_to_charge_percent: battery voltage and charge estimator
// Averages groups of pin readings, scales them by the divider ratio and maps
// the battery voltage onto a Li-ion discharge curve.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_ready     sample_mv
// out       source     out_valid / out_ready   battery_mv, charge_percent
// cfg       sink       cfg_valid / cfg_ready   divider_ratio_q8
//
// A reading that does not close a group leaves the input ready. The reading
// that closes a group holds off new readings until its result is registered:
// the shared serial divider runs 18 steps for the average and 18 more for the
// curve interpolation, and the shift-and-add multiplier runs 12 steps for the
// ratio. A voltage at or past either curve end skips the second divider pass.
// Reset clears the sum, the count, the state and the output valid, and loads
// the ratio with 2.0. A stalled output holds its result while further readings
// of the next group are still taken; the next result waits in the last step.
//
module battery_voltage_to_charge_percent #(
	parameter int SAMPLES_PER_READING = bvcp_pkg::SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bvcp_pkg::SAMPLE_W-1:0] sample_mv,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bvcp_pkg::MV_W-1:0]     battery_mv,
	output logic [bvcp_pkg::PCT_W-1:0]    charge_percent,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bvcp_pkg::RATIO_W-1:0]  divider_ratio_q8
);
	import bvcp_pkg::*;

	// Group size, held to the supported range.
	localparam int GROUP = (SAMPLES_PER_READING < 1) ? 1 :
		(SAMPLES_PER_READING > SAMPLES_MAX) ? SAMPLES_MAX : SAMPLES_PER_READING;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_AVG_GO  = 3'd1;
	localparam logic [2:0] ST_AVG     = 3'd2;
	localparam logic [2:0] ST_MUL     = 3'd3;
	localparam logic [2:0] ST_PCT     = 3'd4;
	localparam logic [2:0] ST_PCT_DIV = 3'd5;
	localparam logic [2:0] ST_OUT     = 3'd6;

	logic [2:0]         state_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   count_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [MV_W-1:0]    mv_q;
	logic [PCT_W-1:0]   pct_q;
	logic [PCT_W-1:0]   base_q;
	logic               out_valid_q;
	logic [MV_W-1:0]    battery_mv_q;
	logic [PCT_W-1:0]   charge_percent_q;

	logic               in_take;
	logic               out_load;

	logic               div_start;
	logic [DIV_DW-1:0]  div_dividend;
	logic [DIV_VW-1:0]  div_divisor;
	logic [DIV_DW-1:0]  div_quo;
	ser_sts_t           div_sts;

	logic [2*RATIO_W-1:0] mul_prod;
	ser_sts_t             mul_sts;

	// Curve segment lookup on the registered battery voltage.
	logic                  seg_hi;
	logic                  seg_lo;
	logic [MV_W-1:0]       seg_mv_lo;
	logic [PCT_W-1:0]      seg_pct_lo;
	logic [SPAN_PCT_W-1:0] seg_span_pct;
	logic [DIV_VW-1:0]     seg_span_mv;
	logic [DIFF_W-1:0]     seg_diff;
	logic [NUM_W-1:0]      seg_num;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		seg_hi       = mv_q >= CURVE_MV[0];
		seg_lo       = mv_q <= CURVE_MV[CURVE_PTS-1];
		seg_mv_lo    = CURVE_MV[CURVE_PTS-1];
		seg_pct_lo   = CURVE_PCT[CURVE_PTS-1];
		seg_span_pct = '0;
		seg_span_mv  = DIV_VW'(1);
		// Segments are disjoint; a voltage equal to a point falls into the
		// segment below that point.
		for (int i = 0; i < CURVE_PTS - 1; i++) begin
			if (mv_q <= CURVE_MV[i] && mv_q > CURVE_MV[i+1]) begin
				seg_mv_lo    = CURVE_MV[i+1];
				seg_pct_lo   = CURVE_PCT[i+1];
				seg_span_pct = SPAN_PCT_W'(CURVE_PCT[i] - CURVE_PCT[i+1]);
				seg_span_mv  = DIV_VW'(CURVE_MV[i] - CURVE_MV[i+1]);
			end
		end
		seg_diff = DIFF_W'(mv_q - seg_mv_lo);
		seg_num  = NUM_W'(seg_diff) * NUM_W'(seg_span_pct);
	end

	// The divider is shared between the group average and the interpolation.
	always_comb begin
		if (state_q == ST_AVG_GO) begin
			div_start    = 1'b1;
			div_dividend = sum_q;
			div_divisor  = DIV_VW'(GROUP);
		end else begin
			div_start    = (state_q == ST_PCT) && !seg_hi && !seg_lo;
			div_dividend = DIV_DW'(seg_num);
			div_divisor  = seg_span_mv;
		end
	end

	bvcp_serdiv #(
		.DW (DIV_DW),
		.VW (DIV_VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.sts      (div_sts)
	);

	// The average never exceeds the largest reading, so its low bits carry
	// the whole quotient.
	bvcp_sermul #(
		.W (RATIO_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   ((state_q == ST_AVG) && div_sts.done),
		.mcand   (div_quo[RATIO_W-1:0]),
		.mplier  (ratio_q),
		.product (mul_prod),
		.sts     (mul_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			ratio_q     <= RATIO_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ratio_q <= divider_ratio_q8;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						sum_q <= sum_q + SUM_W'(sample_mv);
						if (count_q + CNT_W'(1) == CNT_W'(GROUP)) begin
							count_q <= '0;
							state_q <= ST_AVG_GO;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_AVG_GO: begin
					// The divider has latched the sum, so the next group
					// starts from zero.
					sum_q   <= '0;
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					if (div_sts.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_sts.done) begin
						state_q <= ST_PCT;
					end
				end
				ST_PCT: begin
					if (seg_hi || seg_lo) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PCT_DIV;
					end
				end
				ST_PCT_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		// A 24-bit product shifted right by eight always fits in 16 bits, so
		// the battery voltage never needs saturating.
		if ((state_q == ST_MUL) && mul_sts.done) begin
			mv_q <= mul_prod[FRAC_W +: MV_W];
		end
		if (state_q == ST_PCT) begin
			base_q <= seg_pct_lo;
			if (seg_hi) begin
				pct_q <= CURVE_PCT[0];
			end else if (seg_lo) begin
				pct_q <= CURVE_PCT[CURVE_PTS-1];
			end
		end
		if ((state_q == ST_PCT_DIV) && div_sts.done) begin
			pct_q <= base_q + div_quo[PCT_W-1:0];
		end
		if (out_load) begin
			battery_mv_q     <= mv_q;
			charge_percent_q <= pct_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign battery_mv     = battery_mv_q;
	assign charge_percent = charge_percent_q;

`ifndef NO_ASSERTIONS
	// New readings are only taken while both arithmetic units are quiet.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!div_sts.busy && !mul_sts.busy))
		else $error("reading request taken while an arithmetic unit is busy");

	// A divider result is only ever produced where the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_AVG || state_q == ST_PCT_DIV))
		else $error("divider finished outside a waiting state");

	// The group count never reaches the group size.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(GROUP))
		else $error("group count out of range");

	// A presented result always carries a valid percentage.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (charge_percent <= CURVE_PCT[0]))
		else $error("charge percentage above the top of the curve");
`endif

endmodule
